// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; take in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, quiet while reset is held.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

// ----- sv/grc_pkg.sv -----
// Shared types, constants and tables for the grid ray-cast column renderer.
// No dependencies; the design files and the bench refer to it by scoped names.
`timescale 1ns / 1ps

package grc_pkg;

    localparam int MAP_SIDE = 16;
    localparam int MAX_ROWS = 64;
    localparam int DIR_W    = 18;
    localparam int QPOS_W   = 27;
    localparam int DIV_N_W  = 24;
    localparam int DIV_D_W  = 9;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_MAP0 = 3'd0;
    localparam logic [2:0] REG_MAP1 = 3'd1;
    localparam logic [2:0] REG_MAP2 = 3'd2;
    localparam logic [2:0] REG_MAP3 = 3'd3;
    localparam logic [2:0] REG_FOV  = 3'd4;
    localparam logic [2:0] REG_COLS = 3'd5;
    localparam logic [2:0] REG_ROWS = 3'd6;
    localparam logic [2:0] REG_MAXS = 3'd7;

    // Map extent in march units (cell = 655360)
    localparam logic signed [QPOS_W-1:0] MAP_EXTENT = QPOS_W'(MAP_SIDE * 655360);
    localparam logic signed [19:0] CORDIC_X0 = 20'sd39797;
    localparam logic [20:0] TAN_NUM = 21'd1000003;
    localparam logic [20:0] TAN_DEN = 21'd100000;

    typedef struct packed {
        logic [255:0] map_bits;
        logic [14:0]  fov;
        logic [7:0]   cols;
        logic [6:0]   rows;
        logic [7:0]   maxs;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG_SET,
        ST_ANG_DIV,
        ST_COR_SET,
        ST_COR_RUN,
        ST_MARCH,
        ST_EDGE_SET,
        ST_EDGE_RUN,
        ST_CEIL_SET,
        ST_CEIL_DIV,
        ST_ROWS
    } state_t;

    typedef enum logic [3:0] {
        OP_LXVX,
        OP_LYVY,
        OP_LXVY,
        OP_LYVX,
        OP_VXVX,
        OP_VYVY,
        OP_DOTH,
        OP_DOTL,
        OP_CRH,
        OP_CRL
    } edge_op_t;

    typedef enum logic [2:0] {
        GLYPH_BLANK,
        GLYPH_FULL,
        GLYPH_DARK,
        GLYPH_MEDIUM,
        GLYPH_LIGHT,
        GLYPH_HASH,
        GLYPH_X,
        GLYPH_DASH
    } glyph_t;

    // CORDIC arctangent table in binary-angle units
    function automatic logic [13:0] atan_entry(input logic [3:0] i);
        logic [13:0] v;
        case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/grc_regs.sv -----
// Configuration register file on an APB-style port.
// Depends on grc_pkg (cfg_t, register indexes).
`timescale 1ns / 1ps

module grc_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output grc_pkg::cfg_t       cfg
);

    logic [63:0] map0_reg, map1_reg, map2_reg, map3_reg;
    logic [14:0] fov_reg;
    logic [7:0]  cols_reg;
    logic [6:0]  rows_reg;
    logic [7:0]  maxs_reg;
    logic [2:0]  idx;
    logic        wr;

    assign idx    = paddr[5:3];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map0_reg <= '0;
            map1_reg <= '0;
            map2_reg <= '0;
            map3_reg <= '0;
            fov_reg  <= 15'd8192;
            cols_reg <= 8'd120;
            rows_reg <= 7'd40;
            maxs_reg <= 8'd160;
        end
        else if (wr)
        begin
            unique case (idx)
                grc_pkg::REG_MAP0: map0_reg <= pwdata;
                grc_pkg::REG_MAP1: map1_reg <= pwdata;
                grc_pkg::REG_MAP2: map2_reg <= pwdata;
                grc_pkg::REG_MAP3: map3_reg <= pwdata;
                grc_pkg::REG_FOV:  fov_reg  <= pwdata[14:0];
                grc_pkg::REG_COLS: cols_reg <= pwdata[7:0];
                grc_pkg::REG_ROWS: rows_reg <= pwdata[6:0];
                grc_pkg::REG_MAXS: maxs_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            grc_pkg::REG_MAP0: prdata = map0_reg;
            grc_pkg::REG_MAP1: prdata = map1_reg;
            grc_pkg::REG_MAP2: prdata = map2_reg;
            grc_pkg::REG_MAP3: prdata = map3_reg;
            grc_pkg::REG_FOV:  prdata = {49'd0, fov_reg};
            grc_pkg::REG_COLS: prdata = {56'd0, cols_reg};
            grc_pkg::REG_ROWS: prdata = {57'd0, rows_reg};
            grc_pkg::REG_MAXS: prdata = {56'd0, maxs_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.map_bits = {map3_reg, map2_reg, map1_reg, map0_reg};
    assign cfg.fov      = fov_reg;
    assign cfg.cols     = cols_reg;
    assign cfg.rows     = rows_reg;
    assign cfg.maxs     = maxs_reg;

endmodule

// ----- sv/grc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on grc_pkg (divider widths).
`timescale 1ns / 1ps

module grc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [grc_pkg::DIV_N_W-1:0]  dividend,
    input  logic [grc_pkg::DIV_D_W-1:0]  divisor,
    output logic                         done,
    output logic [grc_pkg::DIV_N_W-1:0]  quot,
    output logic                         rem_nz
);

    localparam int NW = grc_pkg::DIV_N_W;
    localparam int DW = grc_pkg::DIV_D_W;
    localparam int CW = $clog2(NW);

    logic          run_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg, dsr_reg;
    logic [NW-1:0] quo_reg;
    logic [DW:0]   trial, diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CW'(NW - 1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                    run_reg <= 1'b0;
            end
        end
    end

    // shift one dividend bit in per cycle, subtract where it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done   = done_reg;
    assign quot   = quo_reg;
    assign rem_nz = rem_reg != '0;

endmodule

// ----- sv/grc_cordic.sv -----
// Iterative CORDIC rotation, one micro-rotation per cycle over a shared shifter.
// Depends on grc_pkg (arctangent table, direction width).
`timescale 1ns / 1ps

module grc_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [15:0]                       ang,
    output logic                              done,
    output logic signed [grc_pkg::DIR_W-1:0]  lx,
    output logic signed [grc_pkg::DIR_W-1:0]  ly
);

    logic               run_reg, done_reg, neg_reg;
    logic [3:0]         i_reg;
    logic signed [19:0] x_reg, y_reg, x_n, y_n, dx, dy;
    logic signed [17:0] z_reg, z_n, z0, zf, atn;
    logic               neg0;
    logic signed [grc_pkg::DIR_W-1:0] lx_reg, ly_reg;

    // fold into the half turn about zero
    always_comb
    begin
        z0   = {{2{ang[15]}}, ang};
        zf   = z0;
        neg0 = 1'b0;
        if (z0 > 18'sd16384)
        begin
            zf   = z0 - 18'sd32768;
            neg0 = 1'b1;
        end
        else if (z0 < -18'sd16384)
        begin
            zf   = z0 + 18'sd32768;
            neg0 = 1'b1;
        end
    end

    assign dx  = y_reg >>> i_reg;
    assign dy  = x_reg >>> i_reg;
    assign atn = $signed({4'b0, grc_pkg::atan_entry(i_reg)});

    always_comb
    begin
        if (!z_reg[17])
        begin
            x_n = x_reg - dx;
            y_n = y_reg + dy;
            z_n = z_reg - atn;
        end
        else
        begin
            x_n = x_reg + dx;
            y_n = y_reg - dy;
            z_n = z_reg + atn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= run_reg && (i_reg == 4'd15);
            if (start)
            begin
                run_reg <= 1'b1;
                i_reg   <= '0;
            end
            else if (run_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == 4'd15)
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= grc_pkg::CORDIC_X0;
            y_reg   <= '0;
            z_reg   <= zf;
            neg_reg <= neg0;
        end
        else if (run_reg)
        begin
            x_reg <= x_n;
            y_reg <= y_n;
            z_reg <= z_n;
            if (i_reg == 4'd15)
            begin
                lx_reg <= neg_reg ? grc_pkg::DIR_W'(-y_n) : grc_pkg::DIR_W'(y_n);
                ly_reg <= neg_reg ? grc_pkg::DIR_W'(-x_n) : grc_pkg::DIR_W'(x_n);
            end
        end
    end

    assign done = done_reg;
    assign lx   = lx_reg;
    assign ly   = ly_reg;

endmodule

// ----- sv/grc_edge.sv -----
// Tile-edge test: one shared registered multiplier stepped through ten
// products per corner over the four corners. Depends on grc_pkg.
`timescale 1ns / 1ps

module grc_edge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [3:0]                        cx,
    input  logic [3:0]                        cy,
    input  logic [15:0]                       px,
    input  logic [15:0]                       py,
    input  logic signed [grc_pkg::DIR_W-1:0]  lx,
    input  logic signed [grc_pkg::DIR_W-1:0]  ly,
    output logic                              done,
    output logic                              edge_hit
);

    logic               run_reg, phase_reg, done_reg;
    logic [1:0]         k_reg;
    grc_pkg::edge_op_t  op_reg, op_succ;
    logic signed [43:0] prod_reg;
    logic signed [35:0] dot_reg, cr_reg, cr_abs;
    logic [34:0]        d2_reg;
    logic [55:0]        lhs_reg, rhs_reg, lhs_fin;
    logic [34:0]        best_d_reg, sec_d_reg;
    logic               best_n_reg, sec_n_reg, sec_v_reg;
    logic [4:0]         cxk, cyk;
    logic signed [17:0] vx, vy;
    logic signed [21:0] op_a, op_b;
    logic               near_k;

    assign cxk = {1'b0, cx} + {4'b0, k_reg[1]};
    assign cyk = {1'b0, cy} + {4'b0, k_reg[0]};
    assign vx  = $signed({1'b0, cxk, 12'b0}) - $signed({2'b0, px});
    assign vy  = $signed({1'b0, cyk, 12'b0}) - $signed({2'b0, py});
    assign cr_abs = cr_reg[35] ? -cr_reg : cr_reg;

    always_comb
    begin
        case (op_reg)
            grc_pkg::OP_LXVX: begin op_a = 22'(lx); op_b = 22'(vx); end
            grc_pkg::OP_LYVY: begin op_a = 22'(ly); op_b = 22'(vy); end
            grc_pkg::OP_LXVY: begin op_a = 22'(lx); op_b = 22'(vy); end
            grc_pkg::OP_LYVX: begin op_a = 22'(ly); op_b = 22'(vx); end
            grc_pkg::OP_VXVX: begin op_a = 22'(vx); op_b = 22'(vx); end
            grc_pkg::OP_VYVY: begin op_a = 22'(vy); op_b = 22'(vy); end
            grc_pkg::OP_DOTH:
            begin
                op_a = $signed({5'b0, dot_reg[33:17]});
                op_b = $signed({1'b0, grc_pkg::TAN_NUM});
            end
            grc_pkg::OP_DOTL:
            begin
                op_a = $signed({5'b0, dot_reg[16:0]});
                op_b = $signed({1'b0, grc_pkg::TAN_NUM});
            end
            grc_pkg::OP_CRH:
            begin
                op_a = $signed({5'b0, cr_abs[33:17]});
                op_b = $signed({1'b0, grc_pkg::TAN_DEN});
            end
            default:
            begin
                op_a = $signed({5'b0, cr_abs[16:0]});
                op_b = $signed({1'b0, grc_pkg::TAN_DEN});
            end
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            grc_pkg::OP_LXVX: op_succ = grc_pkg::OP_LYVY;
            grc_pkg::OP_LYVY: op_succ = grc_pkg::OP_LXVY;
            grc_pkg::OP_LXVY: op_succ = grc_pkg::OP_LYVX;
            grc_pkg::OP_LYVX: op_succ = grc_pkg::OP_VXVX;
            grc_pkg::OP_VXVX: op_succ = grc_pkg::OP_VYVY;
            grc_pkg::OP_VYVY: op_succ = grc_pkg::OP_DOTH;
            grc_pkg::OP_DOTH: op_succ = grc_pkg::OP_DOTL;
            grc_pkg::OP_DOTL: op_succ = grc_pkg::OP_CRH;
            grc_pkg::OP_CRH:  op_succ = grc_pkg::OP_CRL;
            default:          op_succ = grc_pkg::OP_LXVX;
        endcase
    end

    assign lhs_fin = lhs_reg + {17'b0, prod_reg[38:0]};
    assign near_k  = !dot_reg[35] && (dot_reg != '0) && (lhs_fin < rhs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            k_reg     <= '0;
            op_reg    <= grc_pkg::OP_LXVX;
            sec_v_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg   <= 1'b1;
                phase_reg <= 1'b0;
                k_reg     <= '0;
                op_reg    <= grc_pkg::OP_LXVX;
                sec_v_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    op_reg <= op_succ;
                    if (op_reg == grc_pkg::OP_CRL)
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (k_reg == 2'd0)
                            sec_v_reg <= 1'b0;
                        else if (k_reg == 2'd1 || d2_reg < best_d_reg ||
                                 d2_reg < sec_d_reg)
                            sec_v_reg <= 1'b1;
                        if (k_reg == 2'd3)
                        begin
                            run_reg  <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    // datapath: multiply on the first phase, accumulate on the second
    always_ff @(posedge clk)
    begin
        if (run_reg && !phase_reg)
            prod_reg <= op_a * op_b;
        if (run_reg && phase_reg)
        begin
            case (op_reg)
                grc_pkg::OP_LXVX: dot_reg <= prod_reg[35:0];
                grc_pkg::OP_LYVY: dot_reg <= dot_reg + $signed(prod_reg[35:0]);
                grc_pkg::OP_LXVY: cr_reg  <= prod_reg[35:0];
                grc_pkg::OP_LYVX: cr_reg  <= cr_reg - $signed(prod_reg[35:0]);
                grc_pkg::OP_VXVX: d2_reg  <= prod_reg[34:0];
                grc_pkg::OP_VYVY: d2_reg  <= d2_reg + prod_reg[34:0];
                grc_pkg::OP_DOTH: rhs_reg <= {prod_reg[38:0], 17'b0};
                grc_pkg::OP_DOTL: rhs_reg <= rhs_reg + {17'b0, prod_reg[38:0]};
                grc_pkg::OP_CRH:  lhs_reg <= {prod_reg[38:0], 17'b0};
                default:
                begin
                    // insert this corner into the nearest-two ranking
                    if (k_reg == 2'd0 || d2_reg < best_d_reg)
                    begin
                        sec_d_reg  <= best_d_reg;
                        sec_n_reg  <= best_n_reg;
                        best_d_reg <= d2_reg;
                        best_n_reg <= near_k;
                    end
                    else if (!sec_v_reg || d2_reg < sec_d_reg)
                    begin
                        sec_d_reg <= d2_reg;
                        sec_n_reg <= near_k;
                    end
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign edge_hit = best_n_reg | sec_n_reg;

endmodule

// ----- sv/grid_ray_cast_column_renderer.sv -----
// Top level of the grid ray-cast column renderer: sequencer, march datapath
// and row output. Depends on grc_pkg, grc_regs, grc_div, grc_cordic, grc_edge.
//
//  channel   | signals                                   | transfer when
//  ----------+-------------------------------------------+--------------------------
//  command   | start, pos_x, pos_y, view_angle, column   | start high, busy low
//  result    | valid, row, glyph, wall_steps, last       | every cycle valid is high
//  config    | psel, penable, pwrite, paddr, pwdata      | psel&penable&pwrite&pready
//
// One column runs, in order, the ray-angle division, the 16-iteration CORDIC,
// n march steps (n being the steps taken), the edge test when the ray stops
// on a wall (four corners of ten products on the one edge multiplier), the
// ceiling division and the rows. Both divisions take 24 iterations each.
// busy stays high from the command transfer until the cycle in which the last
// row is shown; a new command may transfer in that cycle.
// Rows come out on consecutive cycles, one per cycle; the receiver cannot stall.
// Reset is asynchronous and active low; no clearing pass is needed.
`timescale 1ns / 1ps

module grid_ray_cast_column_renderer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] view_angle,
    input  logic [7:0]  column,
    output logic        busy,
    output logic        valid,
    output logic [5:0]  row,
    output logic [2:0]  glyph,
    output logic [7:0]  wall_steps,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int QW = grc_pkg::QPOS_W;
    localparam int DW = grc_pkg::DIR_W;

    grc_pkg::cfg_t   cfg;
    grc_pkg::state_t state_reg, state_next;

    // operand and march registers
    logic [15:0]          px_reg, py_reg, va_reg, ang_reg, ang_next;
    logic                 neg_reg;
    logic [23:0]          mag_reg;
    logic signed [QW-1:0] qx_reg, qy_reg, qx_next, qy_next;
    logic [7:0]           steps_reg, steps_next;
    logic [3:0]           cx_reg, cy_reg, cx_next, cy_next;
    logic                 edge_reg, edge_next;
    logic signed [10:0]   ceil_reg, ceil_next;
    logic [5:0]           y_reg, y_next;

    // result registers
    logic       valid_reg, valid_next, last_reg, last_next;
    logic [5:0] row_reg, row_next;
    logic [2:0] glyph_reg, glyph_next;
    logic [7:0] wsteps_reg, wsteps_next;

    // effective configuration
    logic [7:0] cols_eff, maxs_eff;
    logic [6:0] h_eff;

    // shared units
    logic                 div_start, div_done, div_rem_nz;
    logic [23:0]          div_dividend, div_quot;
    logic [8:0]           div_divisor;
    logic                 cor_start, cor_done;
    logic signed [DW-1:0] lx, ly;
    logic                 edge_start, edge_done, edge_hit;

    // accept-time angle numerator
    logic signed [9:0] dcol;
    logic [8:0]        dcol_mag;
    logic [23:0]       num_mag;

    // march step
    logic signed [QW-1:0] qx_step, qy_step;
    logic [7:0]           steps_inc;
    logic                 off_map, wall;
    logic [15:0]          cxm, cym;
    logic [3:0]           cx_step, cy_step;

    // ceiling and rows
    logic [7:0]         ceil_diff;
    logic [14:0]        ceil_mag;
    logic [15:0]        ang_q;
    logic [2:0]         shade;
    logic signed [10:0] ys, floor_row;
    logic [6:0]         rem_rows;
    logic               final_row;

    grc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    grc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem_nz   (div_rem_nz)
    );

    grc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .ang   (ang_reg),
        .done  (cor_done),
        .lx    (lx),
        .ly    (ly)
    );

    grc_edge u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (edge_start),
        .cx       (cx_reg),
        .cy       (cy_reg),
        .px       (px_reg),
        .py       (py_reg),
        .lx       (lx),
        .ly       (ly),
        .done     (edge_done),
        .edge_hit (edge_hit)
    );

    // zero counts act as one; rows clamp to the output depth
    assign cols_eff = (cfg.cols == 8'd0) ? 8'd1 : cfg.cols;
    assign maxs_eff = (cfg.maxs == 8'd0) ? 8'd1 : cfg.maxs;
    assign h_eff    = (cfg.rows == 7'd0) ? 7'd1 :
                      (cfg.rows > 7'(grc_pkg::MAX_ROWS)) ? 7'(grc_pkg::MAX_ROWS) : cfg.rows;

    // angle offset numerator (2*column - columns) * fov, sign and magnitude
    assign dcol     = $signed({1'b0, column, 1'b0}) - $signed({2'b0, cols_eff});
    assign dcol_mag = dcol[9] ? 9'(-dcol) : dcol[8:0];
    assign num_mag  = 24'(dcol_mag * cfg.fov);

    // march: advance both axes by one 0.1-cell step
    assign qx_step   = qx_reg + QW'(lx);
    assign qy_step   = qy_reg + QW'(ly);
    assign steps_inc = steps_reg + 8'd1;
    assign off_map   = qx_step[QW-1] || qy_step[QW-1] ||
                       (qx_step >= grc_pkg::MAP_EXTENT) || (qy_step >= grc_pkg::MAP_EXTENT);
    // cell = floor(q / 655360) = floor((q >> 16) / 10), via the reciprocal 205/2048
    assign cxm     = qx_step[23:16] * 8'd205;
    assign cym     = qy_step[23:16] * 8'd205;
    assign cx_step = cxm[14:11];
    assign cy_step = cym[14:11];
    assign wall    = cfg.map_bits[{cy_step, cx_step}];

    // ceiling numerator |h * (n - 20)|
    assign ceil_diff = (steps_reg >= 8'd20) ? (steps_reg - 8'd20) : (8'd20 - steps_reg);
    assign ceil_mag  = 15'(h_eff * ceil_diff);

    // floor division of the angle offset, taken modulo a full turn
    assign ang_q = neg_reg ? (16'(-div_quot) - {15'd0, div_rem_nz}) : div_quot[15:0];

    // wall shade by distance, blank where the ray meets a tile edge
    always_comb
    begin
        if ({steps_reg, 2'b0} <= {2'b0, maxs_eff})
            shade = grc_pkg::GLYPH_FULL;
        else if ({2'b0, steps_reg} + {1'b0, steps_reg, 1'b0} < {2'b0, maxs_eff})
            shade = grc_pkg::GLYPH_DARK;
        else if ({steps_reg, 1'b0} < {1'b0, maxs_eff})
            shade = grc_pkg::GLYPH_MEDIUM;
        else if (steps_reg < maxs_eff)
            shade = grc_pkg::GLYPH_LIGHT;
        else
            shade = grc_pkg::GLYPH_BLANK;
        if (edge_reg)
            shade = grc_pkg::GLYPH_BLANK;
    end

    assign ys        = $signed({5'b0, y_reg});
    assign floor_row = $signed({4'b0, h_eff}) - ceil_reg;
    assign rem_rows  = h_eff - {1'b0, y_reg};
    assign final_row = {1'b0, y_reg} == (h_eff - 7'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            grc_pkg::ST_IDLE:     if (start) state_next = grc_pkg::ST_ANG_SET;
            grc_pkg::ST_ANG_SET:  state_next = grc_pkg::ST_ANG_DIV;
            grc_pkg::ST_ANG_DIV:  if (div_done) state_next = grc_pkg::ST_COR_SET;
            grc_pkg::ST_COR_SET:  state_next = grc_pkg::ST_COR_RUN;
            grc_pkg::ST_COR_RUN:  if (cor_done) state_next = grc_pkg::ST_MARCH;
            grc_pkg::ST_MARCH:
            begin
                if (off_map)
                    state_next = grc_pkg::ST_CEIL_SET;
                else if (wall)
                    state_next = grc_pkg::ST_EDGE_SET;
                else if (steps_inc == maxs_eff)
                    state_next = grc_pkg::ST_CEIL_SET;
            end
            grc_pkg::ST_EDGE_SET: state_next = grc_pkg::ST_EDGE_RUN;
            grc_pkg::ST_EDGE_RUN: if (edge_done) state_next = grc_pkg::ST_CEIL_SET;
            grc_pkg::ST_CEIL_SET: state_next = grc_pkg::ST_CEIL_DIV;
            grc_pkg::ST_CEIL_DIV: if (div_done) state_next = grc_pkg::ST_ROWS;
            grc_pkg::ST_ROWS:     if (final_row) state_next = grc_pkg::ST_IDLE;
            default:              state_next = grc_pkg::ST_IDLE;
        endcase
    end

    // unit controls decoded from the state
    always_comb
    begin
        div_start    = 1'b0;
        cor_start    = 1'b0;
        edge_start   = 1'b0;
        div_dividend = mag_reg;
        div_divisor  = {cols_eff, 1'b0};
        unique case (state_reg)
            grc_pkg::ST_ANG_SET:  div_start = 1'b1;
            grc_pkg::ST_COR_SET:  cor_start = 1'b1;
            grc_pkg::ST_EDGE_SET: edge_start = 1'b1;
            grc_pkg::ST_CEIL_SET:
            begin
                div_start    = 1'b1;
                div_dividend = {9'd0, ceil_mag};
                div_divisor  = {steps_reg, 1'b0};
            end
            default: ;
        endcase
    end

    assign busy = state_reg != grc_pkg::ST_IDLE;

    // datapath next values
    always_comb
    begin
        ang_next    = ang_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        steps_next  = steps_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        edge_next   = edge_reg;
        ceil_next   = ceil_reg;
        y_next      = y_reg;
        valid_next  = 1'b0;
        row_next    = row_reg;
        glyph_next  = glyph_reg;
        wsteps_next = wsteps_reg;
        last_next   = 1'b0;
        case (state_reg)
            grc_pkg::ST_ANG_DIV:
                if (div_done)
                    ang_next = va_reg + ang_q;
            grc_pkg::ST_COR_RUN:
            begin
                // start of march: q = pos * 160
                qx_next    = QW'({px_reg, 7'b0}) + QW'({px_reg, 5'b0});
                qy_next    = QW'({py_reg, 7'b0}) + QW'({py_reg, 5'b0});
                steps_next = 8'd0;
                edge_next  = 1'b0;
            end
            grc_pkg::ST_MARCH:
            begin
                qx_next    = qx_step;
                qy_next    = qy_step;
                steps_next = off_map ? maxs_eff : steps_inc;
                cx_next    = cx_step;
                cy_next    = cy_step;
            end
            grc_pkg::ST_EDGE_RUN:
                if (edge_done)
                    edge_next = edge_hit;
            grc_pkg::ST_CEIL_DIV:
                if (div_done)
                begin
                    // toward zero: negate the magnitude quotient when short
                    ceil_next = (steps_reg < 8'd20) ? 11'(-div_quot) : div_quot[10:0];
                    y_next    = 6'd0;
                end
            grc_pkg::ST_ROWS:
            begin
                valid_next  = 1'b1;
                row_next    = y_reg;
                wsteps_next = steps_reg;
                last_next   = final_row;
                y_next      = y_reg + 6'd1;
                if (ys < ceil_reg)
                    glyph_next = grc_pkg::GLYPH_BLANK;
                else if (ys > ceil_reg && ys <= floor_row)
                    glyph_next = shade;
                else if ({rem_rows, 3'b0} < {3'b0, h_eff})
                    glyph_next = grc_pkg::GLYPH_HASH;
                else if ({1'b0, rem_rows, 2'b0} < {3'b0, h_eff})
                    glyph_next = grc_pkg::GLYPH_X;
                else if ({rem_rows, 3'b0} < ({3'b0, h_eff} + {2'b0, h_eff, 1'b0}))
                    glyph_next = grc_pkg::GLYPH_DASH;
                else
                    glyph_next = grc_pkg::GLYPH_BLANK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grc_pkg::ST_IDLE;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    // hold the command payload from the transfer onwards
    always_ff @(posedge clk)
    begin
        if (state_reg == grc_pkg::ST_IDLE && start)
        begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            va_reg  <= view_angle;
            neg_reg <= dcol[9];
            mag_reg <= num_mag;
        end
        ang_reg    <= ang_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        steps_reg  <= steps_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        edge_reg   <= edge_next;
        ceil_reg   <= ceil_next;
        y_reg      <= y_next;
        row_reg    <= row_next;
        glyph_reg  <= glyph_next;
        wsteps_reg <= wsteps_next;
    end

    assign valid      = valid_reg;
    assign row        = row_reg;
    assign glyph      = glyph_reg;
    assign wall_steps = wsteps_reg;
    assign last       = last_reg;

endmodule

// ----- sv/grc_checker.sv -----
// Port-level checker for the column renderer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       valid,
    input logic [5:0] row,
    input logic [2:0] glyph,
    input logic [7:0] wall_steps,
    input logic       last
);

    `ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_rows_consecutive, clk, rst_n, valid && !last, valid && row == $past(row) + 6'd1)
    `ASSERT_NEXT(a_steps_stable, clk, rst_n, valid && !last, wall_steps == $past(wall_steps))
    `ASSERT_NEXT(a_gap_after_last, clk, rst_n, valid && last, !valid)
    `ASSERT_NOW(a_first_row_zero, clk, rst_n, $rose(valid), row == 6'd0 && glyph == glyph)

endmodule

bind grid_ray_cast_column_renderer grc_checker u_grc_checker (.*);

// ----- bench/tb_grid_ray_cast_column_renderer.sv -----
// Self-checking bench for the grid ray-cast column renderer: a column scoreboard
// predicts every row glyph, and tasks drive the command and APB ports.
// Depends on grc_pkg and grid_ray_cast_column_renderer.
`timescale 1ns / 1ps

// Scoreboard: holds its own register copy, predicts every row of a column
// when the command transfer is noted, and checks each shown row in order.
class column_scoreboard;
    typedef struct {
        logic [5:0]      row;
        grc_pkg::glyph_t glyph;
        logic [7:0]      steps;
        logic            last;
    } row_exp_t;

    logic [255:0] map_bits;
    logic [14:0]  fov;
    logic [7:0]   cols;
    logic [6:0]   rows;
    logic [7:0]   maxs;
    row_exp_t     pending[$];
    int           errors;

    function new();
        map_bits = '0;
        fov      = 15'd8192;
        cols     = 8'd120;
        rows     = 7'd40;
        maxs     = 8'd160;
        errors   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
        case (idx)
            grc_pkg::REG_MAP0: map_bits[63:0]    = val;
            grc_pkg::REG_MAP1: map_bits[127:64]  = val;
            grc_pkg::REG_MAP2: map_bits[191:128] = val;
            grc_pkg::REG_MAP3: map_bits[255:192] = val;
            grc_pkg::REG_FOV:  fov  = val[14:0];
            grc_pkg::REG_COLS: cols = val[7:0];
            grc_pkg::REG_ROWS: rows = val[6:0];
            default:           maxs = val[7:0];
        endcase
    endfunction

    // Rotate (39797, 0) by the binary angle; >>> on int floors like the block.
    function void ray_dir(logic [15:0] ang, output int sn, output int cs);
        int  z, x, y, dx, dy, step_ang;
        bit  flip;
        z = int'(ang);
        x = 39797;
        y = 0;
        flip = 0;
        if (z >= 32768) z -= 65536;
        if (z > 16384) begin z -= 32768; flip = 1; end
        else if (z < -16384) begin z += 32768; flip = 1; end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            step_ang = int'(grc_pkg::atan_entry(i[3:0]));
            if (z >= 0) begin x -= dx; y += dy; z -= step_ang; end
            else begin x += dx; y -= dy; z += step_ang; end
        end
        if (flip) begin x = -x; y = -y; end
        sn = y;
        cs = x;
    endfunction

    // Tile edge: one of the two nearest corners is ahead with tan(angle) < 10.00003.
    function bit near_corner(longint cx, longint cy, longint px, longint py,
                             longint lx, longint ly);
        longint d2[4];
        bit     hit[4];
        longint vx, vy, dot, cr;
        int     a, b;
        a = 0;
        b = -1;
        for (int k = 0; k < 4; k++) begin
            vx = (cx + (k >> 1)) * 4096 - px;
            vy = (cy + (k & 1)) * 4096 - py;
            dot = lx * vx + ly * vy;
            cr = lx * vy - ly * vx;
            if (cr < 0) cr = -cr;
            d2[k] = vx * vx + vy * vy;
            hit[k] = dot > 0 && cr * 100000 < dot * 1000003;
        end
        for (int k = 1; k < 4; k++)
            if (d2[k] < d2[a]) a = k;
        for (int k = 0; k < 4; k++)
            if (k != a && (b < 0 || d2[k] < d2[b])) b = k;
        return hit[a] || hit[b];
    endfunction

    // Note an accepted column command and queue its expected rows.
    function void note_column(logic [15:0] px, logic [15:0] py, logic [15:0] va,
                              logic [7:0] col);
        longint   ncols, nmax, h, num, den, q, qx, qy, cnum, ceil_row, floor_row;
        longint   steps, rem;
        int       lx, ly;
        bit       done, edge_hit;
        int       bit_idx;
        grc_pkg::glyph_t shade, g;
        row_exp_t e;
        ncols = (cols == 0) ? 1 : cols;
        nmax  = (maxs == 0) ? 1 : maxs;
        h     = (rows == 0) ? 1 : rows;
        if (h > grc_pkg::MAX_ROWS) h = grc_pkg::MAX_ROWS;

        num = (2 * longint'(col) - ncols) * longint'(fov);
        den = 2 * ncols;
        q = num / den;
        if (num % den != 0 && num < 0) q--;
        ray_dir(16'(longint'(va) + q), lx, ly);

        steps = 0;
        done = 0;
        edge_hit = 0;
        while (!done && steps < nmax) begin
            steps++;
            qx = longint'(px) * 160 + longint'(lx) * steps;
            qy = longint'(py) * 160 + longint'(ly) * steps;
            if (qx < 0 || qy < 0 || qx >= 16 * 655360 || qy >= 16 * 655360) begin
                done = 1;
                steps = nmax;
            end else begin
                bit_idx = int'(((qy / 655360) * 16 + (qx / 655360)) & 255);
                if (map_bits[bit_idx]) begin
                    done = 1;
                    edge_hit = near_corner(qx / 655360, qy / 655360, px, py, lx, ly);
                end
            end
        end

        cnum = h * (steps - 20);
        den = 2 * steps;
        ceil_row = (cnum >= 0) ? cnum / den : -((-cnum) / den);
        floor_row = h - ceil_row;

        if (4 * steps <= nmax) shade = grc_pkg::GLYPH_FULL;
        else if (3 * steps < nmax) shade = grc_pkg::GLYPH_DARK;
        else if (2 * steps < nmax) shade = grc_pkg::GLYPH_MEDIUM;
        else if (steps < nmax) shade = grc_pkg::GLYPH_LIGHT;
        else shade = grc_pkg::GLYPH_BLANK;
        if (edge_hit) shade = grc_pkg::GLYPH_BLANK;

        for (longint yy = 0; yy < h; yy++) begin
            rem = h - yy;
            if (yy < ceil_row) g = grc_pkg::GLYPH_BLANK;
            else if (yy > ceil_row && yy <= floor_row) g = shade;
            else if (8 * rem < h) g = grc_pkg::GLYPH_HASH;
            else if (4 * rem < h) g = grc_pkg::GLYPH_X;
            else if (8 * rem < 3 * h) g = grc_pkg::GLYPH_DASH;
            else g = grc_pkg::GLYPH_BLANK;
            e.row = 6'(yy);
            e.glyph = g;
            e.steps = 8'(steps);
            e.last = (yy == h - 1);
            pending = {pending, e};
        end
    endfunction

    // Check one shown row against the oldest expectation.
    function void check_row(logic [5:0] row, logic [2:0] glyph, logic [7:0] steps,
                            logic last);
        row_exp_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected row %0d glyph %0d steps %0d last %0d",
                     $time, row, glyph, steps, last);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (row !== e.row || glyph !== e.glyph || steps !== e.steps || last !== e.last)
        begin
            $display("%0t: row mismatch, expected row %0d glyph %0d steps %0d last %0d,",
                     $time, e.row, e.glyph, e.steps, e.last);
            $display("%0t:   actual row %0d glyph %0d steps %0d last %0d",
                     $time, row, glyph, steps, last);
            errors++;
        end
    endfunction
endclass

module tb_grid_ray_cast_column_renderer;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] view_angle;
    logic [7:0]  column;
    logic        busy;
    logic        valid;
    logic [5:0]  row;
    logic [2:0]  glyph;
    logic [7:0]  wall_steps;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    column_scoreboard sb;
    int idle_pct;

    grid_ray_cast_column_renderer dut (
        .clk(clk), .rst_n(rst_n), .start(start), .pos_x(pos_x), .pos_y(pos_y),
        .view_angle(view_angle), .column(column), .busy(busy), .valid(valid),
        .row(row), .glyph(glyph), .wall_steps(wall_steps), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Rows cannot be held off: check every shown row mid-cycle, where the
    // values are those registered at the rising edge that opened the cycle.
    always @(negedge clk)
    begin
        if (rst_n && valid)
            sb.check_row(row, glyph, wall_steps, last);
    end

    // Write one register: setup cycle, then access cycle. Mirror it in the scoreboard.
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic write_map(logic [255:0] m);
        write_reg(grc_pkg::REG_MAP0, m[63:0]);
        write_reg(grc_pkg::REG_MAP1, m[127:64]);
        write_reg(grc_pkg::REG_MAP2, m[191:128]);
        write_reg(grc_pkg::REG_MAP3, m[255:192]);
    endtask

    task automatic write_view(logic [14:0] f, logic [7:0] c, logic [6:0] r,
                              logic [7:0] m);
        write_reg(grc_pkg::REG_FOV, 64'(f));
        write_reg(grc_pkg::REG_COLS, 64'(c));
        write_reg(grc_pkg::REG_ROWS, 64'(r));
        write_reg(grc_pkg::REG_MAXS, 64'(m));
    endtask

    // Hold until every expected row has come, then let the pipeline settle.
    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Send one column command; idle first at the current rate, then hold
    // start until the transfer happens. busy is looked at mid-cycle, so the
    // edge that follows a low busy is the transfer edge.
    task automatic send_column(logic [15:0] px, logic [15:0] py, logic [15:0] va,
                               logic [7:0] col);
        if ($urandom_range(0, 99) < idle_pct)
            repeat ($urandom_range(1, 6)) @(posedge clk);
        @(posedge clk);
        start      <= 1'b1;
        pos_x      <= px;
        pos_y      <= py;
        view_angle <= va;
        column     <= col;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note_column(px, py, va, col);
        start <= 1'b0;
    endtask

    // Map with a solid border and random interior walls.
    function automatic logic [255:0] random_map(int density);
        logic [255:0] m;
        for (int cy = 0; cy < 16; cy++)
            for (int cx = 0; cx < 16; cx++)
                m[cy * 16 + cx] = (cx == 0 || cy == 0 || cx == 15 || cy == 15) ||
                                  ($urandom_range(0, 99) < density);
        return m;
    endfunction

    // Mostly a player in open space looking anywhere; now and then raw noise.
    task automatic random_columns(int n);
        logic [7:0] col;
        for (int i = 0; i < n; i++) begin
            col = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 254))
                                               : 8'($urandom_range(0, sb.cols));
            if ($urandom_range(0, 4) == 0)
                send_column(16'($urandom), 16'($urandom), 16'($urandom), col);
            else
                send_column(16'($urandom_range(4096, 61439)),
                            16'($urandom_range(4096, 61439)), 16'($urandom), col);
            if (i == n / 2)
                drain();
        end
    endtask

    initial
    begin
        logic [255:0] m;
        sb      = new();
        clk     = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        pos_x   = '0;
        pos_y   = '0;
        view_angle = '0;
        column  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        idle_pct = 19;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty map at reset values: no ray can hit a wall.
        send_column(16'h0000, 16'h0000, 16'h0000, 8'd0);
        send_column(16'hFFFF, 16'hFFFF, 16'h8000, 8'd254);
        drain();

        // Border walls, one pillar at cell (5,5); player on the corner (4,4)
        // looking along the diagonal so the ray grazes the pillar's corner.
        m = random_map(0);
        m[5 * 16 + 5] = 1'b1;
        write_map(m);
        write_view(15'd8192, 8'd120, 7'd40, 8'd160);
        send_column(16'h4000, 16'h4000, 16'h2000, 8'd60);
        // Player standing on a corner of a wall cell.
        send_column(16'h5000, 16'h5000, 16'h2000, 8'd60);
        send_column(16'h8000, 16'h8000, 16'h0000, 8'd0);
        send_column(16'h8000, 16'h8000, 16'h4000, 8'd119);
        send_column(16'h8000, 16'h8000, 16'hC000, 8'd254);
        send_column(16'h8000, 16'h8000, 16'hFFFF, 8'd200);
        send_column(16'h7FFF, 16'h1800, 16'h8000, 8'd30);
        drain();

        // Extremes of the view registers; shallow depth hits on the last step.
        write_view(15'd32767, 8'd1, 7'd64, 8'd1);
        send_column(16'h1800, 16'h1800, 16'h8000, 8'd0);
        send_column(16'hF000, 16'h8000, 16'h0000, 8'd254);
        drain();
        write_view(15'd1, 8'd255, 7'd1, 8'd255);
        send_column(16'h8000, 16'h8000, 16'h6000, 8'd254);
        send_column(16'h8000, 16'h2000, 16'hA000, 8'd128);
        drain();
        // Out-of-range settings: zero columns, rows and depth; rows above the maximum.
        write_view(15'd0, 8'd0, 7'd0, 8'd0);
        send_column(16'h8000, 16'h8000, 16'h1234, 8'd3);
        drain();
        write_view(15'd16384, 8'd64, 7'd127, 8'd12);
        send_column(16'h2000, 16'h8000, 16'h8000, 8'd32);
        send_column(16'h1400, 16'h8000, 16'h8000, 8'd32);
        drain();

        // Random part in three idling phases, new settings for each.
        write_map(random_map(12));
        write_view(15'd8192, 8'd120, 7'd40, 8'd160);
        random_columns(65);
        drain();

        idle_pct = 82;
        write_map(random_map(25));
        write_view(15'($urandom_range(1, 32767)), 8'($urandom_range(1, 255)),
                   7'($urandom_range(1, 64)), 8'($urandom_range(1, 255)));
        random_columns(65);
        drain();

        idle_pct = 0;
        write_map({$urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom} & random_map(5));
        write_view(15'($urandom_range(1, 32767)), 8'($urandom_range(1, 255)),
                   7'($urandom_range(8, 24)), 8'($urandom_range(40, 255)));
        random_columns(65);

        drain();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/grc_pkg.sv
sv/grc_regs.sv
sv/grc_div.sv
sv/grc_cordic.sv
sv/grc_edge.sv
sv/grid_ray_cast_column_renderer.sv
sv/grc_checker.sv
bench/tb_grid_ray_cast_column_renderer.sv
